[hdl/lpd_pkg.sv]
// types and constants shared by the length-prefixed record deframer
`default_nettype none
package lpd_pkg;

  localparam int unsigned MASK_W = 60;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned LEN_W  = 7;

  localparam logic [7:0] CMD_WRITE  = 8'h02;
  localparam logic [7:0] CMD_ENABLE = 8'h03;
  localparam logic [7:0] MIN_LEN    = 8'd2;

  localparam logic [POS_W-1:0] OFF_LEN    = 6'd0;
  localparam logic [POS_W-1:0] OFF_CMD    = 6'd1;
  localparam logic [POS_W-1:0] OFF_ID_LO  = 6'd2;
  localparam logic [POS_W-1:0] OFF_ID_HI  = 6'd3;
  localparam logic [POS_W-1:0] OFF_VAL_0  = 6'd6;
  localparam logic [POS_W-1:0] OFF_VAL_1  = 6'd7;
  localparam logic [POS_W-1:0] OFF_VAL_2  = 6'd8;
  localparam logic [POS_W-1:0] OFF_VAL_3  = 6'd9;

  typedef enum logic [1:0] {
    EV_WRITE     = 2'd0,
    EV_HEARTBEAT = 2'd1,
    EV_MALFORMED = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [15:0] ident;
    logic [31:0] value;
  } out_item_t;

endpackage
`default_nettype wire

[hdl/lpd_parser.sv]
// record parser: position tracking, field capture and event decode per byte
`default_nettype none
module lpd_parser import lpd_pkg::*; #(
  parameter int unsigned NUM_IDS      = 60,
  parameter int unsigned PACKET_BYTES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire in_item_t          in_data,
  input  wire logic              cfg_we,
  input  wire logic [MASK_W-1:0] cfg_data,
  output logic                   res_valid,
  output out_item_t              res
);

  localparam logic [LEN_W-1:0] PKT_LEN  = LEN_W'(PACKET_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);
  localparam logic [16:0]      ID_LIM   = 17'(NUM_IDS);
  localparam logic [16:0]      MASK_LIM = 17'(MASK_W);

  logic [MASK_W-1:0] registered_mask;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [POS_W-1:0]  record_offset, record_offset_next;
  logic [LEN_W-1:0]  record_length, record_length_next;
  logic [7:0]        command_code, command_code_next;
  logic [15:0]       id_accum, id_accum_next;
  logic [31:0]       value_accum, value_accum_next;
  logic              packet_halted, packet_halted_next;

  logic [POS_W-1:0]  pos_e, off_e;
  logic [LEN_W-1:0]  len_e, rem;
  logic [7:0]        cmd_e, b;
  logic [15:0]       id_e;
  logic [31:0]       val_e;
  logic              halted_e, start, bad_len, advance, id_ok;

  always_comb begin
    start    = in_data.packet_start;
    b        = in_data.packet_byte;
    pos_e    = start ? '0 : byte_position;
    halted_e = start ? 1'b0 : packet_halted;
    off_e    = start ? '0 : record_offset;
    len_e    = start ? '0 : record_length;
    cmd_e    = start ? '0 : command_code;
    id_e     = start ? '0 : id_accum;
    val_e    = start ? '0 : value_accum;

    rem     = PKT_LEN - {1'b0, pos_e};
    bad_len = (b < MIN_LEN) || (b > {1'b0, rem});
    id_ok   = ({1'b0, id_e} < ID_LIM) && ({1'b0, id_e} < MASK_LIM)
              && registered_mask[id_e[POS_W-1:0]];

    record_offset_next = off_e;
    record_length_next = len_e;
    command_code_next  = cmd_e;
    id_accum_next      = id_e;
    value_accum_next   = val_e;
    packet_halted_next = halted_e;
    advance            = 1'b1;
    res_valid          = 1'b0;
    res                = '0;

    if (!halted_e) begin
      if (off_e == OFF_LEN) begin
        if (bad_len) begin
          res_valid          = 1'b1;
          res.event_kind     = EV_MALFORMED;
          packet_halted_next = 1'b1;
          advance            = 1'b0;
          record_length_next = '0;
          command_code_next  = '0;
          id_accum_next      = '0;
          value_accum_next   = '0;
        end else begin
          record_length_next = b[LEN_W-1:0];
        end
      end else if (off_e == OFF_CMD) begin
        command_code_next = b;
      end else if (cmd_e == CMD_WRITE) begin
        case (off_e)
          OFF_ID_LO: id_accum_next = {8'h00, b};
          OFF_ID_HI: id_accum_next = {b, id_e[7:0]};
          OFF_VAL_0: value_accum_next = {24'h000000, b};
          OFF_VAL_1: value_accum_next = {val_e[31:16], b, val_e[7:0]};
          OFF_VAL_2: value_accum_next = {val_e[31:24], b, val_e[15:0]};
          OFF_VAL_3: begin
            value_accum_next = {b, val_e[23:0]};
            if (id_ok) begin
              res_valid      = 1'b1;
              res.event_kind = EV_WRITE;
              res.ident      = id_e;
              res.value      = {b, val_e[23:0]};
            end
          end
          default: ;
        endcase
      end else if (cmd_e == CMD_ENABLE && off_e == OFF_ID_LO) begin
        res_valid      = 1'b1;
        res.event_kind = EV_HEARTBEAT;
        res.value      = {24'h000000, b};
      end

      if (advance) begin
        if ({1'b0, off_e} + 7'd1 >= record_length_next) begin
          record_offset_next = '0;
          record_length_next = '0;
          command_code_next  = '0;
          id_accum_next      = '0;
          value_accum_next   = '0;
        end else begin
          record_offset_next = off_e + 6'd1;
        end
      end
    end

    if (pos_e == LAST_POS) begin
      byte_position_next = '0;
      packet_halted_next = 1'b0;
      record_offset_next = '0;
      record_length_next = '0;
      command_code_next  = '0;
      id_accum_next      = '0;
      value_accum_next   = '0;
    end else begin
      byte_position_next = pos_e + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      registered_mask <= '0;
    end else if (cfg_we) begin
      registered_mask <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      record_offset <= '0;
      record_length <= '0;
      command_code  <= '0;
      id_accum      <= '0;
      value_accum   <= '0;
      packet_halted <= 1'b0;
    end else if (fire) begin
      byte_position <= byte_position_next;
      record_offset <= record_offset_next;
      record_length <= record_length_next;
      command_code  <= command_code_next;
      id_accum      <= id_accum_next;
      value_accum   <= value_accum_next;
      packet_halted <= packet_halted_next;
    end
  end

  a_halted_clean: assert property (@(posedge clk) disable iff (rst)
    packet_halted |-> (record_offset == '0 && record_length == '0))
    else $error("halted packet holds record state");

  a_offset_in_record: assert property (@(posedge clk) disable iff (rst)
    (record_offset != '0) |-> ({1'b0, record_offset} < record_length))
    else $error("record offset past record length");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, byte_position} < PKT_LEN)
    else $error("byte position past packet end");

  a_malformed_halts: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && res.event_kind == EV_MALFORMED && pos_e != LAST_POS)
      |=> packet_halted)
    else $error("malformed length did not halt packet");

endmodule
`default_nettype wire

[hdl/lpd_out_stage.sv]
// result register between the parser and the output channel
`default_nettype none
module lpd_out_stage import lpd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      fire,
  input  wire logic      res_valid,
  input  wire out_item_t res,
  output logic           take,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic valid;
  out_item_t data;

  assign take      = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fire && res_valid) begin
      data <= res;
    end
  end

endmodule
`default_nettype wire

[hdl/length_prefixed_record_deframer.sv]
// top level of the length-prefixed record deframer
// output: a result appears on out_valid in the cycle after its byte transfer
// throughput: one byte per cycle, a byte is taken whenever the result register is
//   empty or being drained in the same cycle
// reset: synchronous, clears position, record tracking, halt flag, result valid flag
//   and the registered mask
`default_nettype none
module length_prefixed_record_deframer import lpd_pkg::*; #(
  parameter int unsigned NUM_IDS      = 60,
  parameter int unsigned PACKET_BYTES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [MASK_W-1:0] cfg_data
);

  logic      take, fire, res_valid;
  out_item_t res;

  assign cfg_ready = 1'b1;
  assign in_ready  = take;
  assign fire      = in_valid && take;

  lpd_parser #(
    .NUM_IDS      (NUM_IDS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
